@@ hdl/nscr_pkg.sv @@
`timescale 1ns / 1ps

package nscr_pkg;

  localparam int REQ_W      = 2;
  localparam int IN_ID_W    = 32;
  localparam int K_W        = 7;
  localparam int ROW_HITS_W = 7;
  localparam int TOTAL_W    = 32;

  typedef logic [REQ_W-1:0]   req_t;
  typedef logic [K_W-1:0]     k_cfg_t;
  typedef logic [TOTAL_W-1:0] total_t;

  localparam req_t REQ_TRUTH  = 2'd0;
  localparam req_t REQ_APPROX = 2'd1;
  localparam req_t REQ_CLEAR  = 2'd2;

  localparam k_cfg_t K_RESET   = 7'd10;
  localparam total_t TOTAL_MAX = '1;

  // Saturating add for the running totals.
  function automatic total_t sat_add(input total_t a, input total_t b);
    logic [TOTAL_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
  endfunction

endpackage

@@ hdl/nscr_in_if.sv @@
`timescale 1ns / 1ps

interface nscr_in_if
  import nscr_pkg::*;
;
  logic                 valid;
  logic                 ready;
  req_t                 req_type;
  logic [IN_ID_W-1:0]   neighbor_id;

  modport source (output valid, output req_type, output neighbor_id, input ready);
  modport sink   (input valid, input req_type, input neighbor_id, output ready);
endinterface

@@ hdl/nscr_out_if.sv @@
`timescale 1ns / 1ps

interface nscr_out_if
  import nscr_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [ROW_HITS_W-1:0] row_hits;
  total_t                all_hits;
  total_t                rows_done;

  modport source (output valid, output row_hits, output all_hits, output rows_done,
                  input ready);
  modport sink   (input valid, input row_hits, input all_hits, input rows_done,
                  output ready);
endinterface

@@ hdl/neighbor_set_recall_counter_top.sv @@
`timescale 1ns / 1ps

// Recall@k hit counter. Per row, k truth IDs (req_type 0) are followed by k
// approximate IDs (req_type 1); each distinct approximate ID found among the
// truth IDs stored so far counts as a hit. The k-th approximate ID emits one
// word with the row's hit count and the saturating totals, then starts a new
// row. req_type 2 zeroes the totals; code 3 is ignored. Each word is done with
// when it is accepted: it is compared against two rows of MAX_K cells (truth
// and already seen IDs) in parallel, and the cells shift in the new ID as it
// is taken. The result sits in an output register; while it waits on a stalled
// output, every input word is held off, since in_ch.ready follows out_ch.ready.
// k is written through cfg_we/cfg_wdata (0 acts as 1, above MAX_K as MAX_K).
module neighbor_set_recall_counter_top
  import nscr_pkg::*;
#(
  parameter int MAX_K    = 64,
  parameter int ID_WIDTH = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  nscr_in_if.sink        in_ch,
  nscr_out_if.source     out_ch,
  input  logic           cfg_we,
  input  logic [K_W-1:0] cfg_wdata
);

  localparam int CNT_W = $clog2(MAX_K + 1);

  logic [K_W-1:0]        cfg_k_r;
  logic [CNT_W-1:0]      eff_k;
  logic [CNT_W-1:0]      truth_fill_r, truth_fill_nxt;
  logic [CNT_W-1:0]      seen_fill_r, seen_fill_nxt;
  logic [CNT_W-1:0]      approx_taken_r, approx_taken_nxt;
  logic [CNT_W-1:0]      row_hit_r, row_hit_nxt;
  total_t                hit_total_r, hit_total_nxt;
  total_t                row_total_r, row_total_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [ROW_HITS_W-1:0] out_row_hits_r;
  total_t                out_all_hits_r, out_rows_done_r;
  logic                  accept, truth_shift, seen_shift, truth_hit, seen_hit;
  logic                  row_done;
  logic [ID_WIDTH-1:0]   cur_id;

  always_comb begin
    if (cfg_k_r == '0) begin
      eff_k = CNT_W'(1);
    end else if (32'(cfg_k_r) > MAX_K) begin
      eff_k = CNT_W'(MAX_K);
    end else begin
      eff_k = CNT_W'(cfg_k_r);
    end
  end

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign cur_id      = ID_WIDTH'(in_ch.neighbor_id);

  assign truth_shift = accept && (in_ch.req_type == REQ_TRUTH) &&
                       (truth_fill_r < eff_k) && (32'(truth_fill_r) < MAX_K);
  assign seen_shift  = accept && (in_ch.req_type == REQ_APPROX) && !seen_hit &&
                       (32'(seen_fill_r) < MAX_K);

  nscr_chain #(
    .MAX_K    (MAX_K),
    .ID_WIDTH (ID_WIDTH),
    .CNT_W    (CNT_W)
  ) u_truth (
    .clk      (clk),
    .shift_en (truth_shift),
    .new_id   (cur_id),
    .fill     (truth_fill_r),
    .cmp_id   (cur_id),
    .hit      (truth_hit)
  );

  nscr_chain #(
    .MAX_K    (MAX_K),
    .ID_WIDTH (ID_WIDTH),
    .CNT_W    (CNT_W)
  ) u_seen (
    .clk      (clk),
    .shift_en (seen_shift),
    .new_id   (cur_id),
    .fill     (seen_fill_r),
    .cmp_id   (cur_id),
    .hit      (seen_hit)
  );

  always_comb begin
    truth_fill_nxt   = truth_fill_r;
    seen_fill_nxt    = seen_fill_r;
    approx_taken_nxt = approx_taken_r;
    row_hit_nxt      = row_hit_r;
    hit_total_nxt    = hit_total_r;
    row_total_nxt    = row_total_r;
    out_valid_nxt    = out_valid_r && !out_ch.ready;
    row_done         = 1'b0;
    if (accept) begin
      unique case (in_ch.req_type)
        REQ_TRUTH: begin
          if (truth_shift) begin
            truth_fill_nxt = truth_fill_r + CNT_W'(1);
          end
        end
        REQ_APPROX: begin
          approx_taken_nxt = approx_taken_r + CNT_W'(1);
          if (seen_shift) begin
            seen_fill_nxt = seen_fill_r + CNT_W'(1);
          end
          if (!seen_hit && truth_hit) begin
            row_hit_nxt = row_hit_r + CNT_W'(1);
          end
          if (approx_taken_nxt >= eff_k) begin
            row_done         = 1'b1;
            hit_total_nxt    = sat_add(hit_total_r, TOTAL_W'(row_hit_nxt));
            row_total_nxt    = sat_add(row_total_r, TOTAL_W'(1));
            out_valid_nxt    = 1'b1;
            truth_fill_nxt   = '0;
            seen_fill_nxt    = '0;
            approx_taken_nxt = '0;
            row_hit_nxt      = '0;
          end
        end
        REQ_CLEAR: begin
          hit_total_nxt = '0;
          row_total_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_k_r        <= K_RESET;
      truth_fill_r   <= '0;
      seen_fill_r    <= '0;
      approx_taken_r <= '0;
      row_hit_r      <= '0;
      hit_total_r    <= '0;
      row_total_r    <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        cfg_k_r <= cfg_wdata;
      end
      truth_fill_r   <= truth_fill_nxt;
      seen_fill_r    <= seen_fill_nxt;
      approx_taken_r <= approx_taken_nxt;
      row_hit_r      <= row_hit_nxt;
      hit_total_r    <= hit_total_nxt;
      row_total_r    <= row_total_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // The row count is captured before it is cleared for the next row.
  always_ff @(posedge clk) begin
    if (row_done) begin
      out_row_hits_r  <= ROW_HITS_W'(row_hit_r + CNT_W'(!seen_hit && truth_hit));
      out_all_hits_r  <= hit_total_nxt;
      out_rows_done_r <= row_total_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.row_hits  = out_row_hits_r;
  assign out_ch.all_hits  = out_all_hits_r;
  assign out_ch.rows_done = out_rows_done_r;

`ifndef SYNTHESIS
  a_hits_within_seen: assert property (@(posedge clk) disable iff (!rst_n)
    row_hit_r <= seen_fill_r)
    else $error("row hit count exceeds distinct approximate IDs");

  a_seen_within_taken: assert property (@(posedge clk) disable iff (!rst_n)
    (seen_fill_r <= approx_taken_r) && (32'(truth_fill_r) <= MAX_K))
    else $error("row store fill out of bounds");

  a_clear_totals: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_ch.req_type == REQ_CLEAR) |=> (hit_total_r == '0) && (row_total_r == '0))
    else $error("clear request did not zero the totals");
`endif

endmodule

@@ hdl/nscr_cell.sv @@
`timescale 1ns / 1ps

module nscr_cell #(
  parameter int ID_WIDTH = 32
) (
  input  logic                clk,
  input  logic                shift_en,
  input  logic [ID_WIDTH-1:0] id_in,
  input  logic                occupied,
  input  logic [ID_WIDTH-1:0] cmp_id,
  output logic [ID_WIDTH-1:0] id_out,
  output logic                match
);

  logic [ID_WIDTH-1:0] id_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      id_r <= id_in;
    end
  end

  assign id_out = id_r;
  assign match  = occupied && (id_r == cmp_id);

endmodule

@@ hdl/nscr_chain.sv @@
`timescale 1ns / 1ps

module nscr_chain #(
  parameter int MAX_K    = 64,
  parameter int ID_WIDTH = 32,
  parameter int CNT_W    = 7
) (
  input  logic                clk,
  input  logic                shift_en,
  input  logic [ID_WIDTH-1:0] new_id,
  input  logic [CNT_W-1:0]    fill,
  input  logic [ID_WIDTH-1:0] cmp_id,
  output logic                hit
);

  logic [ID_WIDTH-1:0] link [MAX_K+1];
  logic [MAX_K-1:0]    match;

  assign link[0] = new_id;

  // The newest entry sits in cell 0, so the first fill cells hold the row.
  for (genvar i = 0; i < MAX_K; i++) begin : g_cell
    nscr_cell #(
      .ID_WIDTH (ID_WIDTH)
    ) u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .id_in    (link[i]),
      .occupied (32'(i) < 32'(fill)),
      .cmp_id   (cmp_id),
      .id_out   (link[i+1]),
      .match    (match[i])
    );
  end

  assign hit = |match;

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import nscr_pkg::*;

  localparam int ROW_CAP     = 64;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_WORDS = 125;
  localparam int SETTLE      = 4;
  localparam req_t REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [ROW_HITS_W-1:0] row_hits;
    total_t                all_hits;
    total_t                rows_done;
  } recall_word_t;

  typedef struct {
    req_t                req;
    logic [IN_ID_W-1:0]  id;
    bit                  typed;
    recall_word_t        want;
  } directed_word_t;

  localparam recall_word_t NO_WORD = '0;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   cfg_we;
  k_cfg_t cfg_wdata;

  nscr_in_if  in_ch ();
  nscr_out_if out_ch ();

  neighbor_set_recall_counter_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow of the block's row state and totals.
  logic [IN_ID_W-1:0] truth_ids [ROW_CAP];
  logic [IN_ID_W-1:0] seen_ids [ROW_CAP];
  int unsigned truth_cnt, seen_cnt, approx_cnt, row_hit_cnt;
  total_t      hit_sum, row_count;
  k_cfg_t      k_reg;

  recall_word_t recall_words_due [$];
  bit           in_typed;
  recall_word_t typed_want;
  bit           quiet;
  int unsigned  stall_left;
  int unsigned  words_taken, results_checked, mismatches, cycles;

  // The directed words all run at the reset value of k (10).
  directed_word_t directed_words [0:23] = '{
    '{REQ_CLEAR,  32'h0000_0000, 1'b0, NO_WORD},
    '{REQ_UNUSED, 32'hFFFF_FFFF, 1'b0, NO_WORD},
    '{REQ_TRUTH,  32'h0000_0000, 1'b0, NO_WORD},
    '{REQ_APPROX, 32'h0000_0000, 1'b0, NO_WORD},
    '{REQ_APPROX, 32'hFFFF_FFFF, 1'b0, NO_WORD},
    '{REQ_TRUTH,  32'hFFFF_FFFF, 1'b0, NO_WORD},
    '{REQ_TRUTH,  32'hAAAA_AAAA, 1'b0, NO_WORD},
    '{REQ_TRUTH,  32'h5555_5555, 1'b0, NO_WORD},
    '{REQ_TRUTH,  32'h0000_0001, 1'b0, NO_WORD},
    '{REQ_TRUTH,  32'h0000_0002, 1'b0, NO_WORD},
    '{REQ_TRUTH,  32'h0000_0003, 1'b0, NO_WORD},
    '{REQ_TRUTH,  32'h0000_0004, 1'b0, NO_WORD},
    '{REQ_TRUTH,  32'h0000_0005, 1'b0, NO_WORD},
    '{REQ_TRUTH,  32'h0000_0006, 1'b0, NO_WORD},
    '{REQ_TRUTH,  32'h1234_5678, 1'b0, NO_WORD},
    '{REQ_APPROX, 32'hFFFF_FFFF, 1'b0, NO_WORD},
    '{REQ_APPROX, 32'hAAAA_AAAA, 1'b0, NO_WORD},
    '{REQ_APPROX, 32'h5555_5555, 1'b0, NO_WORD},
    '{REQ_APPROX, 32'h1234_5678, 1'b0, NO_WORD},
    '{REQ_APPROX, 32'h0000_0001, 1'b0, NO_WORD},
    '{REQ_APPROX, 32'h0000_0001, 1'b0, NO_WORD},
    '{REQ_CLEAR,  32'h0000_0000, 1'b0, NO_WORD},
    '{REQ_APPROX, 32'h0000_0002, 1'b0, NO_WORD},
    '{REQ_APPROX, 32'h0000_0007, 1'b1, '{7'd5, 32'd5, 32'd1}}
  };

  k_cfg_t k_plan [] = '{7'd0, 7'd1, 7'd2, 7'd3, 7'd64, 7'd5, 7'd127, 7'd4, 7'd65, 7'd8,
                        7'd1, 7'd6};

  function automatic int unsigned clamp_k(input k_cfg_t v);
    if (v == 0) return 1;
    if (v > ROW_CAP) return ROW_CAP;
    return v;
  endfunction

  function automatic total_t add_capped(input total_t a, input total_t b);
    logic [TOTAL_W:0] sum;
    sum = a + b;
    return sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
  endfunction

  // Applies one accepted word to the shadow state; returns 1 when a row completes.
  function automatic bit predict_recall(input req_t req, input logic [IN_ID_W-1:0] id,
                                        output recall_word_t w);
    int unsigned kk;
    bit dup, done;
    kk = clamp_k(k_reg);
    w = NO_WORD;
    done = 1'b0;
    case (req)
      REQ_CLEAR: begin
        hit_sum = '0;
        row_count = '0;
      end
      REQ_TRUTH: begin
        if (truth_cnt < kk) begin
          truth_ids[truth_cnt] = id;
          truth_cnt++;
        end
      end
      REQ_APPROX: begin
        approx_cnt++;
        dup = 1'b0;
        for (int i = 0; i < seen_cnt; i++) if (seen_ids[i] == id) dup = 1'b1;
        if (!dup) begin
          if (seen_cnt < ROW_CAP) begin
            seen_ids[seen_cnt] = id;
            seen_cnt++;
          end
          for (int i = 0; i < truth_cnt; i++) begin
            if (truth_ids[i] == id) begin
              row_hit_cnt++;
              break;
            end
          end
        end
        if (approx_cnt >= kk) begin
          hit_sum = add_capped(hit_sum, total_t'(row_hit_cnt));
          row_count = add_capped(row_count, total_t'(1));
          w.row_hits = row_hit_cnt[ROW_HITS_W-1:0];
          w.all_hits = hit_sum;
          w.rows_done = row_count;
          truth_cnt = 0;
          seen_cnt = 0;
          approx_cnt = 0;
          row_hit_cnt = 0;
          done = 1'b1;
        end
      end
      default: ;
    endcase
    return done;
  endfunction

  task automatic flag_mismatch(input string what, input recall_word_t want,
                               input recall_word_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("MISMATCH %s at %0t: expected hits=%0d total=%0d rows=%0d",
               what, $realtime, want.row_hits, want.all_hits, want.rows_done,
               ", got hits=%0d total=%0d rows=%0d",
               got.row_hits, got.all_hits, got.rows_done);
  endtask

  always @(posedge clk) begin
    recall_word_t w, got, want;
    bit made;
    if (!rst_n) begin
      truth_cnt = 0;
      seen_cnt = 0;
      approx_cnt = 0;
      row_hit_cnt = 0;
      hit_sum = '0;
      row_count = '0;
      k_reg = K_RESET;
    end else begin
      if (cfg_we) k_reg = cfg_wdata;
      if (in_ch.valid && in_ch.ready) begin
        words_taken++;
        made = predict_recall(in_ch.req_type, in_ch.neighbor_id, w);
        if (in_typed) recall_words_due.insert(recall_words_due.size(), typed_want);
        else if (made) recall_words_due.insert(recall_words_due.size(), w);
      end
      if (out_ch.valid && out_ch.ready) begin
        got.row_hits = out_ch.row_hits;
        got.all_hits = out_ch.all_hits;
        got.rows_done = out_ch.rows_done;
        if (recall_words_due.size() == 0) begin
          flag_mismatch("unexpected word", NO_WORD, got);
        end else begin
          want = recall_words_due.pop_front();
          results_checked++;
          if (got.row_hits !== want.row_hits || got.all_hits !== want.all_hits ||
              got.rows_done !== want.rows_done)
            flag_mismatch("row result", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycles,
               recall_words_due.size());
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Mostly short pauses, now and then a long one.
  function automatic int unsigned pause_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (quiet) begin
      out_ch.ready <= 1'b1;
    end else if (stall_left != 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      out_ch.ready <= 1'b1;
      if ($urandom_range(0, 99) < 25) stall_left = pause_len();
    end
  end

  task automatic send_word(input req_t req, input logic [IN_ID_W-1:0] id, input bit typed,
                           input recall_word_t want);
    int unsigned gap;
    in_ch.valid <= 1'b1;
    in_ch.req_type <= req;
    in_ch.neighbor_id <= id;
    in_typed <= typed;
    typed_want <= want;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    gap = (quiet || $urandom_range(0, 99) < 60) ? 0 : pause_len();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // The edge after valid drops settles any push for the last word.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (recall_words_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_k(input k_cfg_t v);
    drain_results();
    repeat (SETTLE) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [IN_ID_W-1:0] fresh_id();
    return ($urandom_range(0, 4) == 0) ? IN_ID_W'($urandom_range(0, 3)) : $urandom;
  endfunction

  // One well-formed row with random content; some rows move approximate IDs
  // ahead of the end of the truth list.
  task automatic plan_row(input int unsigned kk, ref logic [IN_ID_W+REQ_W-1:0] row_words [$]);
    logic [IN_ID_W-1:0] truths [$];
    logic [IN_ID_W-1:0] approx [$];
    logic [IN_ID_W-1:0] id;
    int unsigned r, early, split;
    for (int i = 0; i < kk; i++) begin
      if (truths.size() != 0 && $urandom_range(0, 9) == 0)
        id = truths[$urandom_range(0, truths.size() - 1)];
      else
        id = fresh_id();
      truths.insert(truths.size(), id);
    end
    for (int i = 0; i < kk; i++) begin
      r = $urandom_range(0, 9);
      if (r < 6) id = truths[$urandom_range(0, kk - 1)];
      else if (r < 8 && approx.size() != 0) id = approx[$urandom_range(0, approx.size() - 1)];
      else id = fresh_id();
      approx.insert(approx.size(), id);
    end
    early = ($urandom_range(0, 7) == 0) ? $urandom_range(1, kk) : 0;
    split = $urandom_range(0, kk);
    row_words = {};
    for (int i = 0; i < split; i++)
      row_words.insert(row_words.size(), {REQ_TRUTH, truths[i]});
    for (int i = 0; i < early; i++)
      row_words.insert(row_words.size(), {REQ_APPROX, approx[i]});
    for (int i = split; i < kk; i++)
      row_words.insert(row_words.size(), {REQ_TRUTH, truths[i]});
    for (int i = early; i < kk; i++)
      row_words.insert(row_words.size(), {REQ_APPROX, approx[i]});
  endtask

  initial begin
    logic [IN_ID_W+REQ_W-1:0] row_words [$];
    int unsigned kk, sent;
    req_t noise_req;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.req_type <= REQ_TRUTH;
    in_ch.neighbor_id <= '0;
    in_typed <= 1'b0;
    typed_want <= NO_WORD;
    quiet = 1'b0;
    stall_left = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_words[i])
      send_word(directed_words[i].req, directed_words[i].id, directed_words[i].typed,
                directed_words[i].want);

    foreach (k_plan[p]) begin
      write_k(k_plan[p]);
      kk = clamp_k(k_plan[p]);
      quiet = ($urandom_range(0, 3) == 0);
      sent = 0;
      while (sent < PHASE_WORDS) begin
        plan_row(kk, row_words);
        foreach (row_words[i]) begin
          if ($urandom_range(0, 59) == 0) begin
            case ($urandom_range(0, 3))
              0: noise_req = REQ_CLEAR;
              1: noise_req = REQ_UNUSED;
              2: noise_req = REQ_TRUTH;
              default: noise_req = REQ_APPROX;
            endcase
            send_word(noise_req, fresh_id(), 1'b0, NO_WORD);
          end
          send_word(row_words[i][IN_ID_W+REQ_W-1:IN_ID_W], row_words[i][IN_ID_W-1:0], 1'b0,
                    NO_WORD);
          sent++;
          // Occasionally hold the sender until the result side is empty.
          if ($urandom_range(0, 299) == 0) drain_results();
        end
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (recall_words_due.size() != 0) begin
      mismatches += recall_words_due.size();
      $display("%0d row results never arrived.", recall_words_due.size());
    end
    $display("Ran %0d words through %0d k settings (0, 1, 64 and 127 among them),",
             words_taken, k_plan.size() + 1);
    $display("with early, repeated and surplus IDs, clears and unused codes; %0d rows checked.",
             results_checked);
    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("%0d mismatches.", mismatches);
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/nscr_pkg.sv
hdl/nscr_in_if.sv
hdl/nscr_out_if.sv
hdl/nscr_cell.sv
hdl/nscr_chain.sv
hdl/neighbor_set_recall_counter_top.sv
bench/tb_top.sv
